// File: hw/rtl/rap_pkg.sv
// shared constants, types and tables for the rotate-about-pivot pipeline
package rap_pkg;

   localparam int COORD_WIDTH_DEFAULT   = 24;
   localparam int CORDIC_STAGES_DEFAULT = 16;

   // angle field and its one-bit-wider working form
   localparam int ANGLE_WIDTH     = 17;
   localparam int ANGLE_EXT_WIDTH = ANGLE_WIDTH + 1;
   typedef logic signed [ANGLE_EXT_WIDTH-1:0] rap_angle_type;

   localparam rap_angle_type TURN_UNITS          = 18'sd46080;
   localparam rap_angle_type HALF_UNITS          = 18'sd23040;
   localparam rap_angle_type NEG_HALF_UNITS      = -18'sd23040;
   localparam rap_angle_type QUARTER_UNITS       = 18'sd11520;
   localparam rap_angle_type NEG_QUARTER_UNITS   = -18'sd11520;
   localparam rap_angle_type ZERO_UNITS          = 18'sd0;

   // angle magnitude split as |r| = 45*q + m, z = q*2^22 + round(m*2^22/45)
   localparam int ABS_WIDTH    = 14;
   localparam int RECIP_WIDTH  = 15;
   localparam int RECIP_SHIFT  = 20;
   localparam int QUOT_WIDTH   = 9;
   localparam int REM_WIDTH    = 6;
   localparam int FRAC_WIDTH   = 22;
   localparam int FRAC_ENTRIES = 45;
   localparam logic [RECIP_WIDTH-1:0] RECIP_45      = 15'd23302;
   localparam logic [REM_WIDTH-1:0]   ANGLE_DIVISOR = 6'd45;

   typedef logic [FRAC_ENTRIES-1:0][FRAC_WIDTH-1:0] rap_frac_table_type;

   // rounded m*2^22/45 through shift and subtract
   function automatic rap_frac_table_type build_frac_table();
      rap_frac_table_type tab;
      longint             num;
      longint             quo;
      for (int i = 0; i < FRAC_ENTRIES; i++) begin
         num = longint'(i) * (longint'(1) <<< FRAC_WIDTH) + longint'(ANGLE_DIVISOR >> 1);
         quo = 0;
         for (int b = FRAC_WIDTH; b >= 0; b--) begin
            if (num >= (longint'(ANGLE_DIVISOR) <<< b)) begin
               num = num - (longint'(ANGLE_DIVISOR) <<< b);
               quo = quo + (longint'(1) <<< b);
            end
         end
         tab[i] = FRAC_WIDTH'(quo);
      end
      return tab;
   endfunction

   localparam rap_frac_table_type FRAC_TABLE = build_frac_table();

   // cordic datapath
   localparam int CORDIC_XY_WIDTH = 32;
   localparam int CORDIC_Z_WIDTH  = 33;
   localparam logic signed [CORDIC_XY_WIDTH-1:0] GAIN_Q30 = 32'sd652032874;
   localparam logic signed [CORDIC_Z_WIDTH-1:0]  ONE_Q30  = 33'sd1073741824;

   // how cosine and sine are produced
   localparam logic [1:0] TRIG_SEL_CORDIC = 2'd0;
   localparam logic [1:0] TRIG_SEL_ZERO   = 2'd1;
   localparam logic [1:0] TRIG_SEL_POS90  = 2'd2;
   localparam logic [1:0] TRIG_SEL_NEG90  = 2'd3;

   typedef struct packed {
      logic       flip;
      logic [1:0] trig_sel;
   } rap_ctl_type;

   // atan(2^-k) in units of 2^-32 turn
   function automatic logic signed [CORDIC_Z_WIDTH-1:0] atan_entry(input int k);
      logic signed [CORDIC_Z_WIDTH-1:0] v;
      case (k)
         0:       v = 33'sh020000000;
         1:       v = 33'sh012E4051E;
         2:       v = 33'sh009FB385B;
         3:       v = 33'sh0051111D4;
         4:       v = 33'sh0028B0D43;
         5:       v = 33'sh00145D7E1;
         6:       v = 33'sh000A2F61E;
         7:       v = 33'sh000517C55;
         8:       v = 33'sh00028BE53;
         9:       v = 33'sh000145F2F;
         10:      v = 33'sh0000A2F98;
         11:      v = 33'sh0000517CC;
         12:      v = 33'sh000028BE6;
         13:      v = 33'sh0000145F3;
         14:      v = 33'sh00000A2FA;
         15:      v = 33'sh00000517D;
         16:      v = 33'sh0000028BE;
         17:      v = 33'sh00000145F;
         18:      v = 33'sh000000A30;
         19:      v = 33'sh000000518;
         20:      v = 33'sh00000028C;
         21:      v = 33'sh000000146;
         22:      v = 33'sh0000000A3;
         23:      v = 33'sh000000051;
         24:      v = 33'sh000000029;
         25:      v = 33'sh000000014;
         26:      v = 33'sh00000000A;
         27:      v = 33'sh000000005;
         28:      v = 33'sh000000003;
         29:      v = 33'sh000000001;
         30:      v = 33'sh000000001;
         default: v = 33'sh000000000;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/rap_channels.sv
// request and response channel interfaces of the rotate-about-pivot unit
interface rap_req_if #(
   parameter int COORD_WIDTH = rap_pkg::COORD_WIDTH_DEFAULT
);
   logic                                   valid;
   logic                                   ready;
   logic signed [COORD_WIDTH-1:0]          point_x;
   logic signed [COORD_WIDTH-1:0]          point_y;
   logic signed [COORD_WIDTH-1:0]          pivot_x;
   logic signed [COORD_WIDTH-1:0]          pivot_y;
   logic signed [rap_pkg::ANGLE_WIDTH-1:0] angle;

   modport source (output valid, point_x, point_y, pivot_x, pivot_y, angle, input ready);
   modport sink   (input valid, point_x, point_y, pivot_x, pivot_y, angle, output ready);
endinterface

interface rap_rsp_if #(
   parameter int COORD_WIDTH = rap_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rotated_x;
   logic signed [COORD_WIDTH-1:0] rotated_y;
   logic                          saturated;

   modport source (output valid, rotated_x, rotated_y, saturated, input ready);
   modport sink   (input valid, rotated_x, rotated_y, saturated, output ready);
endinterface

// File: hw/rtl/rap_front.sv
// angle reduction and cordic start angle, three registered stages
module rap_front #(
   parameter int COORD_WIDTH = rap_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      up_valid,
   output logic                                      up_ready,
   input  logic signed [COORD_WIDTH-1:0]             point_x,
   input  logic signed [COORD_WIDTH-1:0]             point_y,
   input  logic signed [COORD_WIDTH-1:0]             pivot_x,
   input  logic signed [COORD_WIDTH-1:0]             pivot_y,
   input  logic signed [rap_pkg::ANGLE_WIDTH-1:0]    angle,
   output logic                                      dn_valid,
   input  logic                                      dn_ready,
   output logic signed [rap_pkg::CORDIC_Z_WIDTH-1:0] dn_z,
   output logic signed [COORD_WIDTH:0]               dn_dx,
   output logic signed [COORD_WIDTH:0]               dn_dy,
   output logic signed [COORD_WIDTH-1:0]             dn_pivot_x,
   output logic signed [COORD_WIDTH-1:0]             dn_pivot_y,
   output rap_pkg::rap_ctl_type                      dn_ctl
);

   localparam int NSTG = 3;
   localparam int MAG_WIDTH = rap_pkg::QUOT_WIDTH + rap_pkg::FRAC_WIDTH;
   localparam int Z_W = rap_pkg::CORDIC_Z_WIDTH;

   // stage handshake
   logic [NSTG-1:0] valid_ff, valid_in, stage_load, src_valid;
   logic [NSTG:0]   stage_ready;

   assign src_valid         = {valid_ff[NSTG-2:0], up_valid};
   assign stage_ready[NSTG] = dn_ready;
   assign up_ready          = stage_ready[0];
   assign dn_valid          = valid_ff[NSTG-1];

   for (genvar g = 0; g < NSTG; g++) begin : g_hs
      assign stage_ready[g] = !valid_ff[g] || stage_ready[g+1];
      assign stage_load[g]  = src_valid[g] && stage_ready[g];
      assign valid_in[g]    = stage_ready[g] ? src_valid[g] : valid_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: wrap to half turn, fold to quarter turn, offsets
   rap_pkg::rap_angle_type ang_ext, ang_wrap, ang_fold, ang_abs;
   logic                            fold_flip;
   rap_pkg::rap_ctl_type            ctl0_in;
   logic [rap_pkg::ABS_WIDTH-1:0]   abs0_in;
   logic signed [COORD_WIDTH:0]     dx0_in, dy0_in;

   always_comb begin
      ang_ext = {angle[rap_pkg::ANGLE_WIDTH-1], angle};
      if (ang_ext >= rap_pkg::HALF_UNITS) begin
         ang_wrap = ang_ext - rap_pkg::TURN_UNITS;
      end else if (ang_ext < rap_pkg::NEG_HALF_UNITS) begin
         ang_wrap = ang_ext + rap_pkg::TURN_UNITS;
      end else begin
         ang_wrap = ang_ext;
      end
      fold_flip = 1'b0;
      if (ang_wrap > rap_pkg::QUARTER_UNITS) begin
         ang_fold  = ang_wrap - rap_pkg::HALF_UNITS;
         fold_flip = 1'b1;
      end else if (ang_wrap < rap_pkg::NEG_QUARTER_UNITS) begin
         ang_fold  = ang_wrap + rap_pkg::HALF_UNITS;
         fold_flip = 1'b1;
      end else begin
         ang_fold = ang_wrap;
      end
      ctl0_in.flip = fold_flip;
      if (ang_fold == rap_pkg::ZERO_UNITS) begin
         ctl0_in.trig_sel = rap_pkg::TRIG_SEL_ZERO;
      end else if (ang_fold == rap_pkg::QUARTER_UNITS) begin
         ctl0_in.trig_sel = rap_pkg::TRIG_SEL_POS90;
      end else if (ang_fold == rap_pkg::NEG_QUARTER_UNITS) begin
         ctl0_in.trig_sel = rap_pkg::TRIG_SEL_NEG90;
      end else begin
         ctl0_in.trig_sel = rap_pkg::TRIG_SEL_CORDIC;
      end
      ang_abs = ang_fold[rap_pkg::ANGLE_EXT_WIDTH-1] ? -ang_fold : ang_fold;
      abs0_in = ang_abs[rap_pkg::ABS_WIDTH-1:0];
      dx0_in  = {point_x[COORD_WIDTH-1], point_x} - {pivot_x[COORD_WIDTH-1], pivot_x};
      dy0_in  = {point_y[COORD_WIDTH-1], point_y} - {pivot_y[COORD_WIDTH-1], pivot_y};
   end

   logic [rap_pkg::ABS_WIDTH-1:0] abs0_ff;
   logic                          neg0_ff;
   rap_pkg::rap_ctl_type          ctl0_ff;
   logic signed [COORD_WIDTH:0]   dx0_ff, dy0_ff;
   logic signed [COORD_WIDTH-1:0] pvx0_ff, pvy0_ff;

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         abs0_ff <= abs0_in;
         neg0_ff <= ang_fold[rap_pkg::ANGLE_EXT_WIDTH-1];
         ctl0_ff <= ctl0_in;
         dx0_ff  <= dx0_in;
         dy0_ff  <= dy0_in;
         pvx0_ff <= pivot_x;
         pvy0_ff <= pivot_y;
      end
   end

   // stage 1: quotient by 45 through reciprocal multiply
   logic [rap_pkg::ABS_WIDTH+rap_pkg::RECIP_WIDTH-1:0] quot_prod;
   assign quot_prod = (rap_pkg::ABS_WIDTH + rap_pkg::RECIP_WIDTH)'(abs0_ff)
                    * (rap_pkg::ABS_WIDTH + rap_pkg::RECIP_WIDTH)'(rap_pkg::RECIP_45);

   logic [rap_pkg::QUOT_WIDTH-1:0] quot1_ff;
   logic [rap_pkg::ABS_WIDTH-1:0]  abs1_ff;
   logic                           neg1_ff;
   rap_pkg::rap_ctl_type           ctl1_ff;
   logic signed [COORD_WIDTH:0]    dx1_ff, dy1_ff;
   logic signed [COORD_WIDTH-1:0]  pvx1_ff, pvy1_ff;

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         quot1_ff <= quot_prod[rap_pkg::RECIP_SHIFT +: rap_pkg::QUOT_WIDTH];
         abs1_ff  <= abs0_ff;
         neg1_ff  <= neg0_ff;
         ctl1_ff  <= ctl0_ff;
         dx1_ff   <= dx0_ff;
         dy1_ff   <= dy0_ff;
         pvx1_ff  <= pvx0_ff;
         pvy1_ff  <= pvy0_ff;
      end
   end

   // stage 2: remainder, fraction table, signed start angle
   logic [rap_pkg::ABS_WIDTH-1:0] quot_times, rem_full;
   logic [rap_pkg::REM_WIDTH-1:0] rem;
   logic [MAG_WIDTH-1:0]          z_mag;
   logic signed [Z_W-1:0]         z_ext, z2_in;

   always_comb begin
      quot_times = rap_pkg::ABS_WIDTH'(quot1_ff) * rap_pkg::ABS_WIDTH'(rap_pkg::ANGLE_DIVISOR);
      rem_full   = abs1_ff - quot_times;
      rem        = rem_full[rap_pkg::REM_WIDTH-1:0];
      z_mag      = {quot1_ff, rap_pkg::FRAC_TABLE[rem]};
      z_ext      = {{(Z_W-MAG_WIDTH){1'b0}}, z_mag};
      z2_in      = neg1_ff ? -z_ext : z_ext;
   end

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         dn_z       <= z2_in;
         dn_ctl     <= ctl1_ff;
         dn_dx      <= dx1_ff;
         dn_dy      <= dy1_ff;
         dn_pivot_x <= pvx1_ff;
         dn_pivot_y <= pvy1_ff;
      end
   end

endmodule

// File: hw/rtl/rap_cordic_cell.sv
// one cordic rotation step with its own register and handshake
module rap_cordic_cell #(
   parameter int COORD_WIDTH = rap_pkg::COORD_WIDTH_DEFAULT,
   parameter int STAGE_IDX   = 0
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       up_valid,
   output logic                                       up_ready,
   input  logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] up_x,
   input  logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] up_y,
   input  logic signed [rap_pkg::CORDIC_Z_WIDTH-1:0]  up_z,
   input  logic signed [COORD_WIDTH:0]                up_dx,
   input  logic signed [COORD_WIDTH:0]                up_dy,
   input  logic signed [COORD_WIDTH-1:0]              up_pivot_x,
   input  logic signed [COORD_WIDTH-1:0]              up_pivot_y,
   input  rap_pkg::rap_ctl_type                       up_ctl,
   output logic                                       dn_valid,
   input  logic                                       dn_ready,
   output logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] dn_x,
   output logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] dn_y,
   output logic signed [rap_pkg::CORDIC_Z_WIDTH-1:0]  dn_z,
   output logic signed [COORD_WIDTH:0]                dn_dx,
   output logic signed [COORD_WIDTH:0]                dn_dy,
   output logic signed [COORD_WIDTH-1:0]              dn_pivot_x,
   output logic signed [COORD_WIDTH-1:0]              dn_pivot_y,
   output rap_pkg::rap_ctl_type                       dn_ctl
);

   localparam int SHIFT = STAGE_IDX % 32;
   localparam logic signed [rap_pkg::CORDIC_Z_WIDTH-1:0] ATAN_STEP = rap_pkg::atan_entry(SHIFT);

   logic valid_ff, valid_in, load;
   logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] x_shift, y_shift, x_in, y_in;
   logic signed [rap_pkg::CORDIC_Z_WIDTH-1:0]  z_in;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;

   always_comb begin
      x_shift = up_x >>> SHIFT;
      y_shift = up_y >>> SHIFT;
      // rotate toward zero residual angle
      if (!up_z[rap_pkg::CORDIC_Z_WIDTH-1]) begin
         x_in = up_x - y_shift;
         y_in = up_y + x_shift;
         z_in = up_z - ATAN_STEP;
      end else begin
         x_in = up_x + y_shift;
         y_in = up_y - x_shift;
         z_in = up_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dn_x       <= x_in;
         dn_y       <= y_in;
         dn_z       <= z_in;
         dn_dx      <= up_dx;
         dn_dy      <= up_dy;
         dn_pivot_x <= up_pivot_x;
         dn_pivot_y <= up_pivot_y;
         dn_ctl     <= up_ctl;
      end
   end

endmodule

// File: hw/rtl/rap_back.sv
// trig select and rounding, matrix multiply, pivot add and clamp
module rap_back #(
   parameter int COORD_WIDTH = rap_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       up_valid,
   output logic                                       up_ready,
   input  logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] up_x,
   input  logic signed [rap_pkg::CORDIC_XY_WIDTH-1:0] up_y,
   input  logic signed [COORD_WIDTH:0]                up_dx,
   input  logic signed [COORD_WIDTH:0]                up_dy,
   input  logic signed [COORD_WIDTH-1:0]              up_pivot_x,
   input  logic signed [COORD_WIDTH-1:0]              up_pivot_y,
   input  rap_pkg::rap_ctl_type                       up_ctl,
   output logic                                       dn_valid,
   input  logic                                       dn_ready,
   output logic signed [COORD_WIDTH-1:0]              rotated_x,
   output logic signed [COORD_WIDTH-1:0]              rotated_y,
   output logic                                       saturated
);

   localparam int NSTG      = 4;
   localparam int TRIG_FRAC = ((61 - COORD_WIDTH) < 30) ? (61 - COORD_WIDTH) : 30;
   localparam int TRIG_SH   = 30 - TRIG_FRAC;
   localparam int Z_W       = rap_pkg::CORDIC_Z_WIDTH;
   localparam int TRIG_W    = TRIG_FRAC + 2;
   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int PROD_W    = DIFF_W + TRIG_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int T_W       = COORD_WIDTH + 3;
   localparam int N_W       = COORD_WIDTH + 4;

   localparam logic signed [Z_W-1:0] TRIG_HALF =
      ({{(Z_W-1){1'b0}}, 1'b1} << TRIG_SH) >> 1;
   localparam logic signed [SUM_W-1:0] PROD_HALF =
      {{(SUM_W-1){1'b0}}, 1'b1} << (TRIG_FRAC - 1);
   localparam logic signed [N_W-1:0] COORD_MAX =
      {{(N_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [N_W-1:0] COORD_MIN =
      {{(N_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   // stage handshake
   logic [NSTG-1:0] valid_ff, valid_in, stage_load, src_valid;
   logic [NSTG:0]   stage_ready;

   assign src_valid         = {valid_ff[NSTG-2:0], up_valid};
   assign stage_ready[NSTG] = dn_ready;
   assign up_ready          = stage_ready[0];
   assign dn_valid          = valid_ff[NSTG-1];

   for (genvar g = 0; g < NSTG; g++) begin : g_hs
      assign stage_ready[g] = !valid_ff[g] || stage_ready[g+1];
      assign stage_load[g]  = src_valid[g] && stage_ready[g];
      assign valid_in[g]    = stage_ready[g] ? src_valid[g] : valid_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: exact angles, half-turn flip, round to trig precision
   logic signed [Z_W-1:0] cos_sel, sin_sel, cos_flip, sin_flip, cos_rnd, sin_rnd;

   always_comb begin
      case (up_ctl.trig_sel)
         rap_pkg::TRIG_SEL_ZERO: begin
            cos_sel = rap_pkg::ONE_Q30;
            sin_sel = '0;
         end
         rap_pkg::TRIG_SEL_POS90: begin
            cos_sel = '0;
            sin_sel = rap_pkg::ONE_Q30;
         end
         rap_pkg::TRIG_SEL_NEG90: begin
            cos_sel = '0;
            sin_sel = -rap_pkg::ONE_Q30;
         end
         default: begin
            cos_sel = {up_x[rap_pkg::CORDIC_XY_WIDTH-1], up_x};
            sin_sel = {up_y[rap_pkg::CORDIC_XY_WIDTH-1], up_y};
         end
      endcase
      cos_flip = up_ctl.flip ? -cos_sel : cos_sel;
      sin_flip = up_ctl.flip ? -sin_sel : sin_sel;
      cos_rnd  = (cos_flip + TRIG_HALF) >>> TRIG_SH;
      sin_rnd  = (sin_flip + TRIG_HALF) >>> TRIG_SH;
   end

   logic signed [TRIG_W-1:0]      cos0_ff, sin0_ff;
   logic signed [DIFF_W-1:0]      dx0_ff, dy0_ff;
   logic signed [COORD_WIDTH-1:0] pvx0_ff, pvy0_ff;

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         cos0_ff <= cos_rnd[TRIG_W-1:0];
         sin0_ff <= sin_rnd[TRIG_W-1:0];
         dx0_ff  <= up_dx;
         dy0_ff  <= up_dy;
         pvx0_ff <= up_pivot_x;
         pvy0_ff <= up_pivot_y;
      end
   end

   // stage 1: four products of the rotation matrix
   logic signed [PROD_W-1:0]      pxc1_ff, pys1_ff, pxs1_ff, pyc1_ff;
   logic signed [COORD_WIDTH-1:0] pvx1_ff, pvy1_ff;

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         pxc1_ff <= PROD_W'(dx0_ff) * PROD_W'(cos0_ff);
         pys1_ff <= PROD_W'(dy0_ff) * PROD_W'(sin0_ff);
         pxs1_ff <= PROD_W'(dx0_ff) * PROD_W'(sin0_ff);
         pyc1_ff <= PROD_W'(dy0_ff) * PROD_W'(cos0_ff);
         pvx1_ff <= pvx0_ff;
         pvy1_ff <= pvy0_ff;
      end
   end

   // stage 2: combine and round back to coordinate scale
   logic signed [SUM_W-1:0] sum_x, sum_y, shr_x, shr_y;

   always_comb begin
      sum_x = SUM_W'(pxc1_ff) - SUM_W'(pys1_ff) + PROD_HALF;
      sum_y = SUM_W'(pxs1_ff) + SUM_W'(pyc1_ff) + PROD_HALF;
      shr_x = sum_x >>> TRIG_FRAC;
      shr_y = sum_y >>> TRIG_FRAC;
   end

   logic signed [T_W-1:0]         tx2_ff, ty2_ff;
   logic signed [COORD_WIDTH-1:0] pvx2_ff, pvy2_ff;

   always_ff @(posedge clock) begin
      if (stage_load[2]) begin
         tx2_ff  <= shr_x[T_W-1:0];
         ty2_ff  <= shr_y[T_W-1:0];
         pvx2_ff <= pvx1_ff;
         pvy2_ff <= pvy1_ff;
      end
   end

   // stage 3: add pivot back and clamp into the output register
   logic signed [N_W-1:0]         new_x, new_y;
   logic signed [COORD_WIDTH-1:0] clip_x, clip_y;
   logic                          sat_x, sat_y;

   always_comb begin
      new_x = {{(N_W-COORD_WIDTH){pvx2_ff[COORD_WIDTH-1]}}, pvx2_ff}
            + {tx2_ff[T_W-1], tx2_ff};
      new_y = {{(N_W-COORD_WIDTH){pvy2_ff[COORD_WIDTH-1]}}, pvy2_ff}
            + {ty2_ff[T_W-1], ty2_ff};
      sat_x = 1'b1;
      sat_y = 1'b1;
      if (new_x > COORD_MAX) begin
         clip_x = COORD_MAX[COORD_WIDTH-1:0];
      end else if (new_x < COORD_MIN) begin
         clip_x = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         clip_x = new_x[COORD_WIDTH-1:0];
         sat_x  = 1'b0;
      end
      if (new_y > COORD_MAX) begin
         clip_y = COORD_MAX[COORD_WIDTH-1:0];
      end else if (new_y < COORD_MIN) begin
         clip_y = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         clip_y = new_y[COORD_WIDTH-1:0];
         sat_y  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[3]) begin
         rotated_x <= clip_x;
         rotated_y <= clip_y;
         saturated <= sat_x || sat_y;
      end
   end

endmodule

// File: hw/rtl/rotate_about_pivot_unit.sv
// top level: rotates a point about a pivot through a chain of cordic cells
//
// usage
//   req_bus carries one word per point: point_x/y and pivot_x/y in signed
//   Q15.8 and a counterclockwise angle in 1/128 degree, taken modulo 360.
//   rsp_bus returns one word per request, in request order: rotated_x/y,
//   clamped to the coordinate range, and saturated when either was clipped.
//   both channels move a word on a clock edge with valid and ready high.
// throughput and stages
//   one word per cycle sustained while rsp_bus is ready. the pipeline is
//   three angle-prep stages, one register per cordic cell, then trig
//   rounding, multiply, combine and clamp. the clamp stage is the
//   response register.
// stalls
//   every stage has its own valid bit and only holds when it is full and
//   the stage after it holds, so bubbles collapse and req_bus stays ready
//   while a finished word waits on rsp_bus, until all stages are full.
// reset
//   synchronous, active high; clears all valid bits, the pipeline comes
//   up empty and ready. no state survives between words.
module rotate_about_pivot_unit #(
   parameter int COORD_WIDTH   = rap_pkg::COORD_WIDTH_DEFAULT,
   parameter int CORDIC_STAGES = rap_pkg::CORDIC_STAGES_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   rap_req_if.sink   req_bus,
   rap_rsp_if.source rsp_bus
);

   localparam int XY_W = rap_pkg::CORDIC_XY_WIDTH;
   localparam int Z_W  = rap_pkg::CORDIC_Z_WIDTH;

   // cell chain links, index 0 is fed by the front end
   logic                          chain_valid   [CORDIC_STAGES+1];
   logic                          chain_ready   [CORDIC_STAGES+1];
   logic signed [XY_W-1:0]        chain_x       [CORDIC_STAGES+1];
   logic signed [XY_W-1:0]        chain_y       [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]         chain_z       [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH:0]   chain_dx      [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH:0]   chain_dy      [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH-1:0] chain_pivot_x [CORDIC_STAGES+1];
   logic signed [COORD_WIDTH-1:0] chain_pivot_y [CORDIC_STAGES+1];
   rap_pkg::rap_ctl_type          chain_ctl     [CORDIC_STAGES+1];

   // angle wrap and fold, start angle in 2^-32 turn, point minus pivot
   rap_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_bus.valid),
      .up_ready   (req_bus.ready),
      .point_x    (req_bus.point_x),
      .point_y    (req_bus.point_y),
      .pivot_x    (req_bus.pivot_x),
      .pivot_y    (req_bus.pivot_y),
      .angle      (req_bus.angle),
      .dn_valid   (chain_valid[0]),
      .dn_ready   (chain_ready[0]),
      .dn_z       (chain_z[0]),
      .dn_dx      (chain_dx[0]),
      .dn_dy      (chain_dy[0]),
      .dn_pivot_x (chain_pivot_x[0]),
      .dn_pivot_y (chain_pivot_y[0]),
      .dn_ctl     (chain_ctl[0])
   );

   // vector starts at the gain-corrected unit length on the x axis
   assign chain_x[0] = rap_pkg::GAIN_Q30;
   assign chain_y[0] = '0;

   // one cell per micro-rotation
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rap_cordic_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .STAGE_IDX   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[g]),
         .up_ready   (chain_ready[g]),
         .up_x       (chain_x[g]),
         .up_y       (chain_y[g]),
         .up_z       (chain_z[g]),
         .up_dx      (chain_dx[g]),
         .up_dy      (chain_dy[g]),
         .up_pivot_x (chain_pivot_x[g]),
         .up_pivot_y (chain_pivot_y[g]),
         .up_ctl     (chain_ctl[g]),
         .dn_valid   (chain_valid[g+1]),
         .dn_ready   (chain_ready[g+1]),
         .dn_x       (chain_x[g+1]),
         .dn_y       (chain_y[g+1]),
         .dn_z       (chain_z[g+1]),
         .dn_dx      (chain_dx[g+1]),
         .dn_dy      (chain_dy[g+1]),
         .dn_pivot_x (chain_pivot_x[g+1]),
         .dn_pivot_y (chain_pivot_y[g+1]),
         .dn_ctl     (chain_ctl[g+1])
      );
   end

   // residual angle of the last cell is not needed
   // cos/sin to product, pivot add, clamp; last stage is the response word
   rap_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[CORDIC_STAGES]),
      .up_ready   (chain_ready[CORDIC_STAGES]),
      .up_x       (chain_x[CORDIC_STAGES]),
      .up_y       (chain_y[CORDIC_STAGES]),
      .up_dx      (chain_dx[CORDIC_STAGES]),
      .up_dy      (chain_dy[CORDIC_STAGES]),
      .up_pivot_x (chain_pivot_x[CORDIC_STAGES]),
      .up_pivot_y (chain_pivot_y[CORDIC_STAGES]),
      .up_ctl     (chain_ctl[CORDIC_STAGES]),
      .dn_valid   (rsp_bus.valid),
      .dn_ready   (rsp_bus.ready),
      .rotated_x  (rsp_bus.rotated_x),
      .rotated_y  (rsp_bus.rotated_y),
      .saturated  (rsp_bus.saturated)
   );

endmodule
